>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the wet-paint compositor.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define WPLC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define WPLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wplc_pkg.sv
// Types and constants of the wet-paint layer compositor.
// No dependencies; used by the divider, the multiplier and the top level.
package wplc_pkg;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_MA,
    ST_WA,
    ST_MB,
    ST_FIN,
    ST_HL_MUL,
    ST_HL_FIN,
    ST_OUT
  } state_t;

  localparam int unsigned MUL_W = 33;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [2*MUL_W-1:0] mul_prod_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_stat_t;

  // exp(-1/512) as a Q64 fraction
  localparam logic [63:0] STEP_Q64  = 64'hFF80_1FFA_AB55_4445;
  localparam logic [15:0] RECIP_NUM = 16'hFF00;
  localparam logic [31:0] ENTRY0    = 32'h0000_8000;
  localparam logic [64:0] B_RND     = 65'h0_0001_0000_0000_0000;
  localparam logic [27:0] WA_RND    = 28'h80;
  localparam logic [22:0] Q_RND     = 23'h4000;
  localparam logic [7:0]  FULL8     = 8'hFF;
  localparam logic [1:0]  LAST_CH   = 2'd2;

  // Table fill step counter: partial-product issue slots, then the update
  localparam logic [2:0] K_LL   = 3'd0;
  localparam logic [2:0] K_LH   = 3'd1;
  localparam logic [2:0] K_HL   = 3'd2;
  localparam logic [2:0] K_HH   = 3'd3;
  localparam logic [2:0] K_FRAC = 3'd4;
  localparam logic [2:0] K_SAT  = 3'd5;

endpackage

>>> sv/wplc_in_if.sv
// Input channel of the compositor: one layer item per transfer.
// Stand-alone; carries valid, ready and the layer payload.
interface wplc_in_if;
  logic        valid;
  logic        ready;
  logic        layer;
  logic [15:0] red_density;
  logic [15:0] red_reflect;
  logic [15:0] green_density;
  logic [15:0] green_reflect;
  logic [15:0] blue_density;
  logic [15:0] blue_reflect;
  logic [8:0]  height_or_water;

  modport source (
    output valid, layer, red_density, red_reflect, green_density, green_reflect,
           blue_density, blue_reflect, height_or_water,
    input  ready
  );

  modport sink (
    input  valid, layer, red_density, red_reflect, green_density, green_reflect,
           blue_density, blue_reflect, height_or_water,
    output ready
  );
endinterface

>>> sv/wplc_out_if.sv
// Result channel of the compositor: one RGB pixel per transfer.
// Stand-alone; carries valid, ready and the pixel payload.
interface wplc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> sv/wplc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on wplc_pkg for the operand and product types.
module wplc_mul import wplc_pkg::*; (
  input  logic      clk,
  input  mul_op_t   a,
  input  mul_op_t   b,
  output mul_prod_t prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

>>> sv/wplc_recip_div.sv
// Restoring divider for 0xff00 / divisor, one quotient bit per cycle.
// Depends on wplc_pkg for the numerator and the status struct.
module wplc_recip_div import wplc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] divisor,
  output div_stat_t   stat
);

  localparam logic [3:0] LAST_STEP = 4'hF;

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [11:0] rem_r;
  logic [15:0] quot_r;
  logic [12:0] rem_sh;
  logic        fits;

  // numerator bits go in from the top
  assign rem_sh = {rem_r, RECIP_NUM[~cnt_r]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? 12'(rem_sh - {1'b0, divisor}) : rem_sh[11:0];
      quot_r <= {quot_r[14:0], fits};
    end
  end

  assign stat.done = done_r;
  assign stat.quot = quot_r;

endmodule

>>> sv/wet_paint_layer_compositor_unit.sv
// Wet-paint layer compositor: blends adsorbed and paint layers into RGB.
// Depends on wplc_pkg, wplc_in_if, wplc_out_if, wplc_mul, wplc_recip_div.
//
//   port     way   handshake          carries
//   in_ch    in    valid / ready      layer, density and reflect per colour, height_or_water
//   out_ch   out   valid / ready      red, green, blue
//   cfg      in    cfg_wr_en          cfg_wr_data -> show_wetness
//
// After reset the render table is filled entry by entry; no layer item is taken
// meanwhile, configuration writes are. One multiplier and the single table read
// port are shared by all channels; each colour passes the RD, MA, WA, MB and FIN
// states. A paint item then ends in the output step, after an HL_MUL / HL_FIN pass
// over the colours when the wetness stripe hits. A waiting pixel holds the block
// in its output step only when the next paint item finishes before it is taken.
`include "assert_macros.svh"

module wet_paint_layer_compositor_unit import wplc_pkg::*; #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  wplc_in_if.sink    in_ch,
  wplc_out_if.source out_ch
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_ENTRIES - 1);
  localparam logic [11:0]   IDX_MAX    = 12'(TABLE_ENTRIES - 1);

  state_t state_r, state_nxt;

  // table fill
  logic [AW-1:0] entry_r;
  logic [2:0]    k_r;
  logic [63:0]   frac_r;
  logic [65:0]   s_r;
  logic [64:0]   b_sum;
  logic [31:0]   rom_mem [TABLE_ENTRIES];
  logic [31:0]   rom_q_r;
  logic [31:0]   rom_wdata;
  logic [AW-1:0] rd_addr;
  logic [11:0]   idx_raw;
  logic          rom_we;
  div_stat_t     div_stat;
  logic          div_start;

  // shared multiplier
  mul_op_t   mul_a, mul_b;
  mul_prod_t prod_r;

  // item and pixel state
  logic        layer_r;
  logic [11:0] dens_r [3];
  logic [11:0] refl_r [3];
  logic [8:0]  hw_r;
  logic [7:0]  col_r [3];
  logic [1:0]  ch_r;
  logic [19:0] wa_r;
  logic [1:0]  phase_r;
  logic        show_wetness_r;
  logic        out_valid_r;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;

  logic        in_ready;
  logic        accept;
  logic        out_load;
  logic [7:0]  base_c;
  logic [7:0]  hl;
  logic [7:0]  inv_c;
  logic [32:0] diff;
  logic [27:0] wa_sum;
  logic [22:0] p_low;
  logic [7:0]  blend_c;
  logic        stripe_on;
  logic        stripe_hit;

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // ---------------------------------------------------------------------
  // datapath terms
  assign base_c     = layer_r ? col_r[ch_r] : {1'b1, hw_r[8:2]};
  assign hl         = FULL8 - hw_r[8:1];
  assign inv_c      = FULL8 - col_r[ch_r];
  assign diff       = {25'b0, base_c} - {13'b0, wa_r};
  assign wa_sum     = prod_r[27:0] + WA_RND;
  assign p_low      = prod_r[22:0] + Q_RND;
  assign blend_c    = wa_r[7:0] + p_low[22:15];
  assign stripe_on  = show_wetness_r && (hw_r[8:1] != 8'd0);
  assign stripe_hit = stripe_on && ((phase_r == 2'd0) || (phase_r == 2'd3));

  assign idx_raw = dens_r[ch_r];
  assign rd_addr = (idx_raw > IDX_MAX) ? LAST_ENTRY : idx_raw[AW-1:0];

  assign b_sum     = {1'b0, frac_r} + B_RND;
  assign rom_wdata = (entry_r == '0) ? ENTRY0 : {div_stat.quot, b_sum[64:49]};

  // ---------------------------------------------------------------------
  // shared units
  wplc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  wplc_recip_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (12'(entry_r)),
    .stat    (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[entry_r] <= rom_wdata;
    end
    rom_q_r <= rom_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (div_stat.done && (entry_r == LAST_ENTRY)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_RD;
      end
      ST_RD:  state_nxt = ST_MA;
      ST_MA:  state_nxt = ST_WA;
      ST_WA:  state_nxt = ST_MB;
      ST_MB:  state_nxt = ST_FIN;
      ST_FIN: begin
        priority if (ch_r != LAST_CH) state_nxt = ST_RD;
        else if (!layer_r)            state_nxt = ST_IDLE;
        else if (stripe_hit)          state_nxt = ST_HL_MUL;
        else                          state_nxt = ST_OUT;
      end
      ST_HL_MUL: state_nxt = ST_HL_FIN;
      ST_HL_FIN: state_nxt = (ch_r == LAST_CH) ? ST_OUT : ST_HL_MUL;
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs and multiplier operand selection
  always_comb begin
    in_ready  = 1'b0;
    rom_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_INIT: begin
        div_start = (k_r == K_LL);
        rom_we    = div_stat.done;
        // partial products of frac * step, low halves first
        unique case (k_r)
          K_LL: begin
            mul_a = {1'b0, frac_r[31:0]};
            mul_b = {1'b0, STEP_Q64[31:0]};
          end
          K_LH: begin
            mul_a = {1'b0, frac_r[31:0]};
            mul_b = {1'b0, STEP_Q64[63:32]};
          end
          K_HL: begin
            mul_a = {1'b0, frac_r[63:32]};
            mul_b = {1'b0, STEP_Q64[31:0]};
          end
          K_HH: begin
            mul_a = {1'b0, frac_r[63:32]};
            mul_b = {1'b0, STEP_Q64[63:32]};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_IDLE: in_ready = 1'b1;
      ST_MA: begin
        mul_a = {21'b0, refl_r[ch_r]};
        mul_b = {17'b0, rom_q_r[31:16]};
      end
      ST_MB: begin
        mul_a = diff;
        mul_b = {17'b0, rom_q_r[15:0]};
      end
      ST_HL_MUL: begin
        mul_a = {25'b0, inv_c};
        mul_b = {25'b0, hl};
      end
      ST_OUT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_INIT;
      entry_r        <= '0;
      k_r            <= K_LL;
      frac_r         <= STEP_Q64;
      ch_r           <= '0;
      phase_r        <= '0;
      show_wetness_r <= 1'b0;
      out_valid_r    <= 1'b0;
      col_r[0]       <= '0;
      col_r[1]       <= '0;
      col_r[2]       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        show_wetness_r <= cfg_wr_data;
      end

      if (state_r == ST_INIT) begin
        if (div_stat.done) begin
          k_r     <= K_LL;
          entry_r <= entry_r + AW'(1);
        end else if (k_r != K_SAT) begin
          k_r <= k_r + 3'd1;
        end
        // first entries take the step itself; later ones chain the product
        if ((k_r == K_FRAC) && (entry_r > AW'(1))) begin
          frac_r <= 64'(s_r[65:32]) + prod_r[63:0];
        end
      end

      priority if (accept) begin
        ch_r <= '0;
      end else if (state_r == ST_FIN) begin
        col_r[ch_r] <= blend_c;
        if (ch_r != LAST_CH) begin
          ch_r <= ch_r + 2'd1;
        end else begin
          ch_r <= '0;
          if (layer_r && stripe_on) begin
            phase_r <= phase_r + 2'd1;
          end
        end
      end else if (state_r == ST_HL_FIN) begin
        col_r[ch_r] <= FULL8 - prod_r[15:8];
        if (ch_r != LAST_CH) begin
          ch_r <= ch_r + 2'd1;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      layer_r   <= in_ch.layer;
      dens_r[0] <= in_ch.red_density[15:4];
      dens_r[1] <= in_ch.green_density[15:4];
      dens_r[2] <= in_ch.blue_density[15:4];
      refl_r[0] <= in_ch.red_reflect[15:4];
      refl_r[1] <= in_ch.green_reflect[15:4];
      refl_r[2] <= in_ch.blue_reflect[15:4];
      hw_r      <= in_ch.height_or_water;
    end

    if (state_r == ST_WA) begin
      wa_r <= wa_sum[27:8];
    end

    // gather the high half of the 128-bit product across the issue slots
    if (state_r == ST_INIT) begin
      unique case (k_r)
        K_LH:    s_r <= 66'(prod_r[63:32]);
        K_HL:    s_r <= s_r + 66'(prod_r[63:0]);
        K_HH:    s_r <= s_r + 66'(prod_r[63:0]);
        default: s_r <= s_r;
      endcase
    end

    if (out_load) begin
      out_red_r   <= col_r[0];
      out_green_r <= col_r[1];
      out_blue_r  <= col_r[2];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = out_red_r;
  assign out_ch.green = out_green_r;
  assign out_ch.blue  = out_blue_r;

  // ---------------------------------------------------------------------
  // checks
  `WPLC_ASSERT_NEXT(a_busy_after_transfer, in_ch.valid && in_ch.ready, !in_ch.ready, "ready held after transfer")
  `WPLC_ASSERT_IMPL(a_phase_on_paint, !$stable(phase_r), ($past(state_r) == ST_FIN) && $past(layer_r), "stripe phase moved outside paint finish")
  `WPLC_ASSERT_IMPL(a_out_from_seq, $rose(out_valid_r), $past(state_r) == ST_OUT, "pixel raised outside output step")
  `WPLC_ASSERT_IMPL(a_fill_after_div, rom_we, (state_r == ST_INIT) && (k_r == K_SAT), "table written before product chain settled")

endmodule
